// ----- sv/tidtt_pkg.sv -----
`default_nettype none
package tidtt_pkg;

  localparam int TIDTT_DEPTH = 16;
  localparam int MS_PER_SEC  = 1000;

  // register indexes
  localparam int REG_MAX_ENTRIES     = 0;
  localparam int REG_TIMEOUT_SECONDS = 1;

  localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;
  localparam logic [11:0] TIMEOUT_RST     = 12'd5;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DROP,
    S_DONE
  } state_t;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [15:0] local_id;
    logic [15:0] upstream_id;
    logic [31:0] client_addr;
    logic [15:0] udp_port;
    logic [15:0] query_type;
    logic [31:0] stamp;
    logic [31:0] seq_no;
  } entry_t;

endpackage
`default_nettype wire

// ----- sv/transaction_id_translation_table.sv -----
// Clear and a create on a table that is not full go from request accept straight to the result.
// Create on a full table and remove take one pass over the slot memory.
// Lookup takes a match pass, then an expiry drop pass; the one read port sets this.
// Requests are taken one at a time; the next is taken while a result waits.
// Reset (synchronous): all slots invalid, live count 0, next upstream ID 1,
// max_entries 16, timeout_seconds 5. Slot contents stay undefined until written.
`default_nettype none
module transaction_id_translation_table #(
  parameter int TABLE_DEPTH = tidtt_pkg::TIDTT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] local_id,
  input  wire logic [31:0] client_addr,
  input  wire logic [15:0] client_port_in,
  input  wire logic [15:0] query_type_in,
  input  wire logic [15:0] search_id,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [15:0]      assigned_id,
  output logic [15:0]      found_local_id,
  output logic [31:0]      found_client_addr,
  output logic [15:0]      found_client_port,
  output logic [15:0]      found_query_type,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(tidtt_pkg::entry_t);

  // configuration registers
  logic [4:0]  max_entries;
  logic [11:0] timeout_seconds;
  logic [21:0] thr_ms;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries     <= tidtt_pkg::MAX_ENTRIES_RST;
      timeout_seconds <= tidtt_pkg::TIMEOUT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        1'(tidtt_pkg::REG_MAX_ENTRIES):     max_entries     <= pwdata[4:0];
        1'(tidtt_pkg::REG_TIMEOUT_SECONDS): timeout_seconds <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      1'(tidtt_pkg::REG_MAX_ENTRIES):     prdata = {27'd0, max_entries};
      1'(tidtt_pkg::REG_TIMEOUT_SECONDS): prdata = {20'd0, timeout_seconds};
      default:                            prdata = '0;
    endcase
  end

  // timeout in ms; floor(d/1000) >= T is the same as d >= 1000*T
  always_ff @(posedge clk) begin
    thr_ms <= 22'(timeout_seconds * 22'(tidtt_pkg::MS_PER_SEC));
  end

  // control state
  tidtt_pkg::state_t state, state_next;
  tidtt_pkg::op_t    op_r;
  logic [TABLE_DEPTH-1:0] valid;
  logic [CW-1:0]     live_count;
  logic [CW-1:0]     cap;
  logic [31:0]       insert_sequence;
  logic [15:0]       next_upstream;

  // latched request
  logic [31:0] now_r;
  logic [15:0] search_r;
  logic [15:0] local_r;
  logic [31:0] addr_r;
  logic [15:0] port_r;
  logic [15:0] qtype_r;

  // scan pipeline
  logic          issuing;
  logic [IW-1:0] cnt;
  logic          d_valid;
  logic [IW-1:0] d_idx;
  logic          scan_end;

  // best match so far
  logic          found;
  logic [31:0]   best_age;
  logic [IW-1:0] best_idx;
  logic [15:0]   f_local;
  logic [31:0]   f_addr;
  logic [15:0]   f_port;
  logic [15:0]   f_qtype;

  // slot memory
  tidtt_pkg::entry_t rd_entry, wr_entry;
  logic [EW-1:0]     ram_rdata;
  logic              ram_we;
  logic [IW-1:0]     free_idx;
  logic              free_any;

  tidtt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (wr_entry),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  assign rd_entry = tidtt_pkg::entry_t'(ram_rdata);

  always_comb begin
    wr_entry.local_id    = local_r;
    wr_entry.upstream_id = next_upstream;
    wr_entry.client_addr = addr_r;
    wr_entry.udp_port    = port_r;
    wr_entry.query_type  = qtype_r;
    wr_entry.stamp       = now_r;
    wr_entry.seq_no      = insert_sequence;
  end

  // capacity limit
  always_comb begin
    if (32'(max_entries) < 32'(TABLE_DEPTH)) begin
      cap = CW'(max_entries);
    end else begin
      cap = CW'(TABLE_DEPTH);
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  // per-slot evaluation of the entry coming out of memory
  logic        slot_live;
  logic        slot_expired;
  logic [31:0] slot_age;
  logic        id_hit;
  logic        newer;
  logic        passed;
  logic        take;
  logic        drop_scan;

  assign slot_live    = d_valid && valid[d_idx];
  assign slot_expired = (now_r - rd_entry.stamp) >= {10'd0, thr_ms};
  assign slot_age     = insert_sequence - rd_entry.seq_no;
  assign id_hit       = rd_entry.upstream_id == search_r;
  assign newer        = !found || (slot_age < best_age);
  assign passed       = !found || (slot_age < best_age)
                        || ((slot_age == best_age) && (d_idx < best_idx));
  assign scan_end     = d_valid && (d_idx == IW'(TABLE_DEPTH - 1));

  assign take = (state == tidtt_pkg::S_SCAN) && slot_live && id_hit && newer
                && ((op_r == tidtt_pkg::OP_REMOVE)
                    || ((op_r == tidtt_pkg::OP_LOOKUP) && !slot_expired));

  assign drop_scan = slot_live && slot_expired
                     && (((state == tidtt_pkg::S_SCAN) && (op_r == tidtt_pkg::OP_CREATE))
                         || ((state == tidtt_pkg::S_DROP) && passed));

  // completion
  logic accept;
  logic fin;
  logic create_ok;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state != tidtt_pkg::S_IDLE;
  assign fin       = (state == tidtt_pkg::S_DONE) && (!out_valid || !out_stall);
  assign create_ok = (live_count < cap) && free_any;
  assign ram_we    = fin && (op_r == tidtt_pkg::OP_CREATE) && create_ok;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tidtt_pkg::S_IDLE: begin
        if (accept) begin
          if ((tidtt_pkg::op_t'(opcode) == tidtt_pkg::OP_CLEAR)
              || ((tidtt_pkg::op_t'(opcode) == tidtt_pkg::OP_CREATE)
                  && (live_count < cap))) begin
            state_next = tidtt_pkg::S_DONE;
          end else begin
            state_next = tidtt_pkg::S_SCAN;
          end
        end
      end
      tidtt_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = (op_r == tidtt_pkg::OP_LOOKUP) ? tidtt_pkg::S_DROP
                                                      : tidtt_pkg::S_DONE;
        end
      end
      tidtt_pkg::S_DROP: begin
        if (scan_end) begin
          state_next = tidtt_pkg::S_DONE;
        end
      end
      tidtt_pkg::S_DONE: begin
        if (fin) begin
          state_next = tidtt_pkg::S_IDLE;
        end
      end
      default: state_next = tidtt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tidtt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= tidtt_pkg::op_t'(opcode);
      now_r    <= now_ms;
      search_r <= search_id;
      local_r  <= local_id;
      addr_r   <= client_addr;
      port_r   <= client_port_in;
      qtype_r  <= query_type_in;
    end
  end

  // scan address sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      cnt     <= '0;
      d_valid <= 1'b0;
    end else begin
      d_valid <= issuing;
      d_idx   <= cnt;
      if ((accept && (state_next == tidtt_pkg::S_SCAN))
          || ((state == tidtt_pkg::S_SCAN) && (state_next == tidtt_pkg::S_DROP))) begin
        issuing <= 1'b1;
        cnt     <= '0;
      end else if (issuing) begin
        if (cnt == IW'(TABLE_DEPTH - 1)) begin
          issuing <= 1'b0;
        end else begin
          cnt <= cnt + IW'(1);
        end
      end
    end
  end

  // best match tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_age <= slot_age;
      best_idx <= d_idx;
      f_local  <= rd_entry.local_id;
      f_addr   <= rd_entry.client_addr;
      f_port   <= rd_entry.udp_port;
      f_qtype  <= rd_entry.query_type;
    end
  end

  // slot valid bits and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= '0;
      live_count      <= '0;
      insert_sequence <= '0;
      next_upstream   <= 16'd1;
    end else if (drop_scan) begin
      valid[d_idx] <= 1'b0;
      live_count   <= live_count - CW'(1);
    end else if (fin) begin
      case (op_r) inside
        tidtt_pkg::OP_CREATE: begin
          if (create_ok) begin
            valid[free_idx] <= 1'b1;
            live_count      <= live_count + CW'(1);
            insert_sequence <= insert_sequence + 32'd1;
            next_upstream   <= (next_upstream == 16'hFFFF) ? 16'd1
                                                           : next_upstream + 16'd1;
          end
        end
        tidtt_pkg::OP_LOOKUP, tidtt_pkg::OP_REMOVE: begin
          if (found) begin
            valid[best_idx] <= 1'b0;
            live_count      <= live_count - CW'(1);
          end
        end
        default: begin
          valid      <= '0;
          live_count <= '0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload for the request being finished
  logic [1:0]  status_next;
  logic [15:0] assigned_id_next;
  logic [15:0] found_local_id_next;
  logic [31:0] found_client_addr_next;
  logic [15:0] found_client_port_next;
  logic [15:0] found_query_type_next;

  always_comb begin
    status_next            = tidtt_pkg::ST_OK;
    assigned_id_next       = '0;
    found_local_id_next    = '0;
    found_client_addr_next = '0;
    found_client_port_next = '0;
    found_query_type_next  = '0;
    case (op_r)
      tidtt_pkg::OP_CREATE: begin
        if (create_ok) begin
          assigned_id_next = next_upstream;
        end else begin
          status_next = tidtt_pkg::ST_FULL;
        end
      end
      tidtt_pkg::OP_LOOKUP: begin
        if (found) begin
          found_local_id_next    = f_local;
          found_client_addr_next = f_addr;
          found_client_port_next = f_port;
          found_query_type_next  = f_qtype;
        end else begin
          status_next = tidtt_pkg::ST_NOTFOUND;
        end
      end
      tidtt_pkg::OP_REMOVE: begin
        if (!found) begin
          status_next = tidtt_pkg::ST_NOTFOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status            <= status_next;
      assigned_id       <= assigned_id_next;
      found_local_id    <= found_local_id_next;
      found_client_addr <= found_client_addr_next;
      found_client_port <= found_client_port_next;
      found_query_type  <= found_query_type_next;
    end
  end

`ifndef SYNTHESIS
  // live count tracks the valid bits
  a_live_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(live_count))
    else $error("live count out of step with valid bits");

  // upstream ID zero is never handed out
  a_next_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_upstream != 16'd0)
    else $error("next upstream ID is zero");

  // no slot write while the memory is being scanned
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == tidtt_pkg::S_SCAN || state == tidtt_pkg::S_DROP) |-> !ram_we)
    else $error("slot write during scan");

  // a finished request always leaves a result behind
  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    fin |=> out_valid && (state == tidtt_pkg::S_IDLE))
    else $error("result not presented after completion");
`endif

endmodule
`default_nettype wire

// ----- sv/tidtt_ram.sv -----
`default_nettype none
module tidtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
